[hw/rtl/ihex_pkg.sv]
// Shared types, codes and helper functions for the Intel HEX record decoder.
`default_nettype none

package ihex_pkg;

    typedef enum logic [1:0] {
        PH_LINE_START = 2'd0,
        PH_SKIP       = 2'd1,
        PH_RECORD     = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DATA        = 3'd0,
        KIND_RECORD_OK   = 3'd1,
        KIND_END_OF_FILE = 3'd2,
        KIND_CSUM_ERROR  = 3'd3,
        KIND_UNSUPPORTED = 3'd4,
        KIND_IGNORED     = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] byte_address;
        logic [7:0]  data_byte;
    } t_result;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] REC_DATA     = 8'h00;
    localparam logic [7:0] REC_EOF      = 8'h01;
    localparam logic [7:0] REC_EXT_SEG  = 8'h02;
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_EXT_LIN  = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    localparam logic [9:0] COUNT_MAX    = 10'd1023;
    localparam logic [9:0] LEN_OVERHEAD = 10'd10;

    localparam logic [8:0] IDX_COUNT    = 9'd0;
    localparam logic [8:0] IDX_ADDR_HI  = 9'd1;
    localparam logic [8:0] IDX_ADDR_LO  = 9'd2;
    localparam logic [8:0] IDX_TYPE     = 9'd3;
    localparam logic [8:0] IDX_DATA0    = 9'd4;
    localparam logic [8:0] IDX_DATA1    = 9'd5;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ihex_parse.sv]
// Record parser state and the per-character decode of the Intel HEX decoder.
`default_nettype none

module ihex_parse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_char,
    output logic                  o_res_valid,
    output ihex_pkg::t_result     o_res
);

    ihex_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_hi, n_hi;
    logic [9:0]  r_cnt, n_cnt;
    logic [7:0]  r_dc, n_dc;
    logic [7:0]  r_kind, n_kind;
    logic [15:0] r_off, n_off;
    logic [15:0] r_pb, n_pb;
    logic [31:0] r_ext, n_ext;
    logic [7:0]  r_sum, n_sum;
    logic        r_halted, n_halted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ihex_pkg::PH_LINE_START;
            r_hi     <= 4'd0;
            r_cnt    <= 10'd0;
            r_dc     <= 8'd0;
            r_kind   <= 8'd0;
            r_off    <= 16'd0;
            r_pb     <= 16'd0;
            r_ext    <= 32'd0;
            r_sum    <= 8'd0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hi     <= n_hi;
            r_cnt    <= n_cnt;
            r_dc     <= n_dc;
            r_kind   <= n_kind;
            r_off    <= n_off;
            r_pb     <= n_pb;
            r_ext    <= n_ext;
            r_sum    <= n_sum;
            r_halted <= n_halted;
        end
    end

    always_comb begin
        logic       eol;
        logic [3:0] hv;
        logic [7:0] b;
        logic [8:0] idx;
        logic [8:0] data_idx;
        logic [9:0] expect_len;

        n_phase  = r_phase;
        n_hi     = r_hi;
        n_cnt    = r_cnt;
        n_dc     = r_dc;
        n_kind   = r_kind;
        n_off    = r_off;
        n_pb     = r_pb;
        n_ext    = r_ext;
        n_sum    = r_sum;
        n_halted = r_halted;

        o_res_valid        = 1'b0;
        o_res.kind         = ihex_pkg::KIND_DATA;
        o_res.byte_address = 32'd0;
        o_res.data_byte    = 8'd0;

        eol        = (i_char == ihex_pkg::CHAR_CR) || (i_char == ihex_pkg::CHAR_LF);
        hv         = ihex_pkg::hex_value(i_char);
        b          = {r_hi, hv};
        idx        = r_cnt[9:1];
        data_idx   = idx - ihex_pkg::IDX_DATA0;
        expect_len = {1'b0, r_dc, 1'b0} + ihex_pkg::LEN_OVERHEAD;

        if (i_fire && !r_halted) begin
            unique case (r_phase)
                ihex_pkg::PH_RECORD: begin
                    if (eol) begin
                        n_phase     = ihex_pkg::PH_LINE_START;
                        o_res_valid = 1'b1;
                        if (r_cnt != expect_len) begin
                            o_res.kind = ihex_pkg::KIND_IGNORED;
                        end else if (r_sum != 8'd0) begin
                            o_res.kind = ihex_pkg::KIND_CSUM_ERROR;
                            n_halted   = 1'b1;
                        end else begin
                            unique case (r_kind)
                                ihex_pkg::REC_DATA: begin
                                    o_res.kind = ihex_pkg::KIND_RECORD_OK;
                                end
                                ihex_pkg::REC_EOF: begin
                                    o_res.kind = ihex_pkg::KIND_END_OF_FILE;
                                    n_halted   = 1'b1;
                                end
                                ihex_pkg::REC_EXT_SEG: begin
                                    o_res.kind = ihex_pkg::KIND_RECORD_OK;
                                    n_ext      = {12'd0, r_pb, 4'd0};
                                end
                                ihex_pkg::REC_EXT_LIN: begin
                                    o_res.kind = ihex_pkg::KIND_RECORD_OK;
                                    n_ext      = {r_pb, 16'd0};
                                end
                                ihex_pkg::REC_START_SEG, ihex_pkg::REC_START_LIN: begin
                                    o_res.kind = ihex_pkg::KIND_UNSUPPORTED;
                                    n_halted   = 1'b1;
                                end
                                default: begin
                                    o_res.kind = ihex_pkg::KIND_IGNORED;
                                end
                            endcase
                        end
                    end else if (r_cnt != ihex_pkg::COUNT_MAX) begin
                        n_cnt = r_cnt + 10'd1;
                        if (!r_cnt[0]) begin
                            n_hi = hv;
                        end else begin
                            n_sum = r_sum + b;
                            priority if (idx == ihex_pkg::IDX_COUNT) begin
                                n_dc = b;
                            end else if (idx == ihex_pkg::IDX_ADDR_HI ||
                                         idx == ihex_pkg::IDX_ADDR_LO) begin
                                n_off = {r_off[7:0], b};
                            end else if (idx == ihex_pkg::IDX_TYPE) begin
                                n_kind = b;
                            end else begin
                                if (idx == ihex_pkg::IDX_DATA0 || idx == ihex_pkg::IDX_DATA1) begin
                                    n_pb = {r_pb[7:0], b};
                                end
                                if (r_kind == ihex_pkg::REC_DATA && data_idx < {1'b0, r_dc}) begin
                                    o_res_valid        = 1'b1;
                                    o_res.kind         = ihex_pkg::KIND_DATA;
                                    o_res.byte_address = r_ext + {16'd0, r_off}
                                                         + {23'd0, data_idx};
                                    o_res.data_byte    = b;
                                end
                            end
                        end
                    end
                end
                ihex_pkg::PH_SKIP: begin
                    if (eol) begin
                        n_phase = ihex_pkg::PH_LINE_START;
                    end
                end
                ihex_pkg::PH_LINE_START: begin
                    if (i_char == ihex_pkg::CHAR_COLON) begin
                        n_phase = ihex_pkg::PH_RECORD;
                        n_hi    = 4'd0;
                        n_cnt   = 10'd0;
                        n_dc    = 8'd0;
                        n_kind  = 8'd0;
                        n_off   = 16'd0;
                        n_pb    = 16'd0;
                        n_sum   = 8'd0;
                    end else if (!eol) begin
                        n_phase = ihex_pkg::PH_SKIP;
                    end
                end
                default: begin
                    n_phase = ihex_pkg::PH_LINE_START;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/intel_hex_record_decoder_core.sv]
// Top level of the Intel HEX record decoder: input register, parser and result register.
// A character passes through the input register and, when it gives a result, through the
// result register; characters that give no result vanish.
// Throughput: one character per cycle while the result register is empty or not stalled.
// Reset: synchronous, active low; it clears both valid flags and returns the parser to
// the start of a line with a zero extended base and the halt flag cleared.
`default_nettype none

module intel_hex_record_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_character,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_result_kind,
    output logic [31:0]      o_byte_address,
    output logic [7:0]       o_data_byte
);

    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_char;
    logic              r_out_valid, n_out_valid;
    ihex_pkg::t_result r_res;
    logic              fire;
    logic              res_valid;
    ihex_pkg::t_result res;
    logic              in_xfer;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_xfer    = i_in_valid && !o_in_stall;

    ihex_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_char      (r_char),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (fire && res_valid) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_char <= i_character;
        end
        if (fire && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_res.kind;
    assign o_byte_address = r_res.byte_address;
    assign o_data_byte    = r_res.data_byte;

endmodule

`default_nettype wire

[hw/rtl/ihex_checker.sv]
// Port-level checker for the Intel HEX record decoder and its bind to the top level.
`default_nettype none

module ihex_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_result_kind,
    input wire logic [31:0] o_byte_address,
    input wire logic [7:0]  o_data_byte
);

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_kind_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_kind <= ihex_pkg::KIND_IGNORED))
        else $error("result kind out of range");

    a_status_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != ihex_pkg::KIND_DATA)
        |-> (o_byte_address == 32'd0 && o_data_byte == 8'd0))
        else $error("status result with nonzero address or data");

    a_silent_after_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall &&
         (o_result_kind == ihex_pkg::KIND_END_OF_FILE ||
          o_result_kind == ihex_pkg::KIND_CSUM_ERROR ||
          o_result_kind == ihex_pkg::KIND_UNSUPPORTED))
        |=> !o_out_valid)
        else $error("result after a halting status");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_result_kind) && $stable(o_byte_address)
             && $stable(o_data_byte)))
        else $error("stalled result changed");

endmodule

bind intel_hex_record_decoder_core ihex_checker u_ihex_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_kind  (o_result_kind),
    .o_byte_address (o_byte_address),
    .o_data_byte    (o_data_byte)
);

`default_nettype wire

[sim/intel_hex_record_decoder_core_tb.sv]
// Self-checking testbench for the Intel HEX record decoder core.
`timescale 1ns / 1ps

module intel_hex_record_decoder_core_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_CHARS  = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_character = 8'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_result_kind;
    logic [31:0] o_byte_address;
    logic [7:0]  o_data_byte;

    intel_hex_record_decoder_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_character    (i_character),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_byte_address (o_byte_address),
        .o_data_byte    (o_data_byte)
    );

    ihex_pkg::t_result due_decodes[$];
    ihex_pkg::t_result want;
    int          err_count = 0;
    int          cycle_count = 0;
    int          kind_seen[8];
    int          record_chars = 0;
    int          record_lines = 0;
    bit          quiet_sender = 1'b0;
    logic [7:0]  rec_bytes[$];
    logic [15:0] next_offset = 16'd0;
    string       halt_name = "none";

    // Decoder state as seen from the character stream.
    ihex_pkg::t_phase dec_phase = ihex_pkg::PH_LINE_START;
    logic [3:0]  dec_hi_nib = 4'd0;
    logic [9:0]  dec_len = 10'd0;
    logic [7:0]  dec_count = 8'd0;
    logic [7:0]  dec_type = 8'd0;
    logic [15:0] dec_offset = 16'd0;
    logic [15:0] dec_seg = 16'd0;
    logic [31:0] dec_base = 32'd0;
    logic [7:0]  dec_sum = 8'd0;
    bit          dec_halted = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (!is_hex_digit(c)) begin
            return 4'd0;
        end
        if (c <= 8'h39) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'd0, n};
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_hex_digit(c) || c == ihex_pkg::CHAR_CR || c == ihex_pkg::CHAR_LF);
        return c;
    endfunction

    function automatic logic [7:0] line_char(input bit first);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == ihex_pkg::CHAR_CR || c == ihex_pkg::CHAR_LF ||
                   (first && c == ihex_pkg::CHAR_COLON));
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task post_decode(input ihex_pkg::t_kind kind, input logic [31:0] addr,
                     input logic [7:0] data);
        ihex_pkg::t_result r;
        r.kind = kind;
        r.byte_address = addr;
        r.data_byte = data;
        due_decodes.push_back(r);
    endtask

    task close_line();
        if (dec_len != {1'b0, dec_count, 1'b0} + ihex_pkg::LEN_OVERHEAD) begin
            post_decode(ihex_pkg::KIND_IGNORED, 32'd0, 8'd0);
        end else if (dec_sum != 8'd0) begin
            dec_halted = 1'b1;
            post_decode(ihex_pkg::KIND_CSUM_ERROR, 32'd0, 8'd0);
        end else begin
            case (dec_type)
                ihex_pkg::REC_DATA: post_decode(ihex_pkg::KIND_RECORD_OK, 32'd0, 8'd0);
                ihex_pkg::REC_EOF: begin
                    dec_halted = 1'b1;
                    post_decode(ihex_pkg::KIND_END_OF_FILE, 32'd0, 8'd0);
                end
                ihex_pkg::REC_EXT_SEG: begin
                    dec_base = {12'd0, dec_seg, 4'd0};
                    post_decode(ihex_pkg::KIND_RECORD_OK, 32'd0, 8'd0);
                end
                ihex_pkg::REC_EXT_LIN: begin
                    dec_base = {dec_seg, 16'd0};
                    post_decode(ihex_pkg::KIND_RECORD_OK, 32'd0, 8'd0);
                end
                ihex_pkg::REC_START_SEG, ihex_pkg::REC_START_LIN: begin
                    dec_halted = 1'b1;
                    post_decode(ihex_pkg::KIND_UNSUPPORTED, 32'd0, 8'd0);
                end
                default: post_decode(ihex_pkg::KIND_IGNORED, 32'd0, 8'd0);
            endcase
        end
    endtask

    task decode_char(input logic [7:0] c);
        logic       eol;
        logic [9:0] pos;
        logic [8:0] idx;
        logic [8:0] data_pos;
        logic [7:0] b;
        eol = (c == ihex_pkg::CHAR_CR) || (c == ihex_pkg::CHAR_LF);
        if (!dec_halted) begin
            case (dec_phase)
                ihex_pkg::PH_RECORD: begin
                    if (eol) begin
                        dec_phase = ihex_pkg::PH_LINE_START;
                        close_line();
                    end else if (dec_len < ihex_pkg::COUNT_MAX) begin
                        pos = dec_len;
                        dec_len = dec_len + 10'd1;
                        if (!pos[0]) begin
                            dec_hi_nib = nibble_of(c);
                        end else begin
                            b = {dec_hi_nib, nibble_of(c)};
                            idx = pos[9:1];
                            dec_sum = dec_sum + b;
                            if (idx == ihex_pkg::IDX_COUNT) begin
                                dec_count = b;
                            end else if (idx == ihex_pkg::IDX_ADDR_HI ||
                                         idx == ihex_pkg::IDX_ADDR_LO) begin
                                dec_offset = {dec_offset[7:0], b};
                            end else if (idx == ihex_pkg::IDX_TYPE) begin
                                dec_type = b;
                            end else begin
                                if (idx == ihex_pkg::IDX_DATA0 ||
                                    idx == ihex_pkg::IDX_DATA1) begin
                                    dec_seg = {dec_seg[7:0], b};
                                end
                                data_pos = idx - ihex_pkg::IDX_DATA0;
                                if (dec_type == ihex_pkg::REC_DATA &&
                                    data_pos < {1'b0, dec_count}) begin
                                    post_decode(ihex_pkg::KIND_DATA,
                                                dec_base + {16'd0, dec_offset} +
                                                {23'd0, data_pos}, b);
                                end
                            end
                        end
                    end
                end
                ihex_pkg::PH_SKIP: begin
                    if (eol) begin
                        dec_phase = ihex_pkg::PH_LINE_START;
                    end
                end
                default: begin
                    if (eol) begin
                        dec_phase = ihex_pkg::PH_LINE_START;
                    end else if (c == ihex_pkg::CHAR_COLON) begin
                        dec_phase = ihex_pkg::PH_RECORD;
                        dec_hi_nib = 4'd0;
                        dec_len = 10'd0;
                        dec_count = 8'd0;
                        dec_type = 8'd0;
                        dec_offset = 16'd0;
                        dec_seg = 16'd0;
                        dec_sum = 8'd0;
                    end else begin
                        dec_phase = ihex_pkg::PH_SKIP;
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_char(i_character);
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_decodes.size() == 0) begin
                    $display("%0t: unexpected result kind %0d addr %h byte %h", $time,
                             o_result_kind, o_byte_address, o_data_byte);
                    err_count++;
                end else begin
                    want = due_decodes.pop_front();
                    kind_seen[want.kind]++;
                    if (o_result_kind !== want.kind || o_byte_address !== want.byte_address ||
                        o_data_byte !== want.data_byte) begin
                        $display({"%0t: mismatch: expected kind %0d addr %h byte %h, ",
                                  "got kind %0d addr %h byte %h"},
                                 $time, want.kind, want.byte_address, want.data_byte,
                                 o_result_kind, o_byte_address, o_data_byte);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        int  run;
        bit  stall_now;
        run = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                stall_now = !stall_now;
                if (stall_now) begin
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                        $urandom_range(1, 3);
                end else begin
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                                                        $urandom_range(1, 6);
                end
            end
            run--;
            i_out_stall <= stall_now;
        end
    end

    task send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_character <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_decodes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task send_eol();
        case ($urandom_range(0, 2))
            0: send_char(ihex_pkg::CHAR_CR);
            1: send_char(ihex_pkg::CHAR_LF);
            default: begin
                send_char(ihex_pkg::CHAR_CR);
                send_char(ihex_pkg::CHAR_LF);
            end
        endcase
    endtask

    task start_record(input logic [7:0] cnt, input logic [15:0] addr, input logic [7:0] rtype);
        rec_bytes = {};
        rec_bytes.push_back(cnt);
        rec_bytes.push_back(addr[15:8]);
        rec_bytes.push_back(addr[7:0]);
        rec_bytes.push_back(rtype);
    endtask

    task add_data(input int n);
        repeat (n) rec_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task close_record(input bit bad);
        logic [7:0] s;
        s = 8'd0;
        foreach (rec_bytes[i]) s = s + rec_bytes[i];
        s = 8'd0 - s;
        if (bad) begin
            s = s + 8'($urandom_range(1, 255));
        end
        rec_bytes.push_back(s);
    endtask

    // A zero nibble may go out as a non-hex character, which decodes to the same value.
    task send_record(input int trim, input int pad, input int junk_pct, input bit terminate);
        int         n_nib;
        logic [3:0] nib;
        n_nib = 2 * rec_bytes.size() - trim;
        send_char(ihex_pkg::CHAR_COLON);
        for (int i = 0; i < n_nib; i++) begin
            nib = (i % 2 == 0) ? rec_bytes[i / 2][7:4] : rec_bytes[i / 2][3:0];
            if (nib == 4'd0 && $urandom_range(1, 100) <= junk_pct) begin
                send_char(junk_char());
            end else begin
                send_char(digit_char(nib));
            end
        end
        repeat (pad) send_char(digit_char(4'($urandom_range(0, 15))));
        record_chars += 1 + n_nib + pad;
        record_lines++;
        if (terminate) begin
            send_eol();
        end
    endtask

    task send_skip_line(input int n);
        send_char(line_char(1'b1));
        repeat (n) send_char(line_char(1'b0));
        send_eol();
    endtask

    task test_data_records();
        start_record(8'd3, 16'h0000, ihex_pkg::REC_DATA);
        rec_bytes.push_back(8'h00);
        rec_bytes.push_back(8'hFF);
        rec_bytes.push_back(8'h5A);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd0, 16'hFFFF, ihex_pkg::REC_DATA);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd4, 16'hFFFE, ihex_pkg::REC_DATA);
        add_data(4);
        close_record(1'b0);
        send_record(0, 0, 50, 1'b1);
    endtask

    task test_base_records();
        start_record(8'd2, 16'h0000, ihex_pkg::REC_EXT_LIN);
        rec_bytes.push_back(8'hFF);
        rec_bytes.push_back(8'hFF);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        // The second byte lands past the top of the 32-bit space and wraps to zero.
        start_record(8'd2, 16'hFFFF, ihex_pkg::REC_DATA);
        add_data(2);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd2, 16'h0000, ihex_pkg::REC_EXT_SEG);
        rec_bytes.push_back(8'hFF);
        rec_bytes.push_back(8'hFF);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd1, 16'hFFFF, ihex_pkg::REC_DATA);
        add_data(1);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        // With no data byte, the segment value comes from the checksum byte.
        start_record(8'd0, 16'h0000, ihex_pkg::REC_EXT_SEG);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd1, 16'h0010, ihex_pkg::REC_DATA);
        add_data(1);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd2, 16'h0000, ihex_pkg::REC_EXT_LIN);
        rec_bytes.push_back(8'h00);
        rec_bytes.push_back(8'h00);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
    endtask

    task test_ignored_lines();
        start_record(8'd1, 16'h0020, 8'h06);
        add_data(1);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd0, 16'h0000, 8'hFF);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        start_record(8'd2, 16'h0030, ihex_pkg::REC_DATA);
        add_data(2);
        close_record(1'b0);
        send_record(1, 0, 0, 1'b1);
        start_record(8'd0, 16'h0000, ihex_pkg::REC_EOF);
        close_record(1'b1);
        send_record(0, 2, 0, 1'b1);
        start_record(8'd4, 16'h0100, ihex_pkg::REC_DATA);
        repeat (4) rec_bytes.push_back(8'h00);
        close_record(1'b0);
        send_record(0, 0, 100, 1'b1);
        send_skip_line(10);
        send_char(ihex_pkg::CHAR_CR);
        send_char(ihex_pkg::CHAR_LF);
        // A record without its line end gives no status until the line end arrives.
        start_record(8'd2, 16'h0200, ihex_pkg::REC_DATA);
        add_data(2);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b0);
        wait_idle();
        send_char(ihex_pkg::CHAR_LF);
    endtask

    task test_overlong_line();
        start_record(8'hFF, 16'h1000, ihex_pkg::REC_DATA);
        add_data(256);
        send_record(0, 1026 - 2 * rec_bytes.size(), 0, 1'b1);
    endtask

    task test_random_stream();
        int         start_chars;
        int         r;
        int         n;
        logic [7:0] rtype;
        start_chars = record_chars;
        while (record_chars - start_chars < RANDOM_CHARS) begin
            quiet_sender = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0) begin
                next_offset = 16'($urandom_range(0, 65535));
            end
            r = $urandom_range(0, 99);
            if (r < 50) begin
                n = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8) : $urandom_range(9, 32);
                start_record(8'(n), next_offset, ihex_pkg::REC_DATA);
                add_data(n);
                close_record(1'b0);
                send_record(0, 0, ($urandom_range(0, 3) == 0) ? 40 : 0, 1'b1);
                next_offset = next_offset + 16'(n);
            end else if (r < 64) begin
                start_record(8'd2, 16'($urandom_range(0, 65535)),
                             (r < 58) ? ihex_pkg::REC_EXT_LIN : ihex_pkg::REC_EXT_SEG);
                if ($urandom_range(0, 2) == 0) begin
                    add_data(2);
                end else begin
                    rec_bytes.push_back(8'd0);
                    rec_bytes.push_back(8'($urandom_range(0, 3)));
                end
                close_record(1'b0);
                send_record(0, 0, 20, 1'b1);
            end else if (r < 70) begin
                rtype = 8'($urandom_range(6, 255));
                n = $urandom_range(0, 4);
                start_record(8'(n), 16'($urandom_range(0, 65535)), rtype);
                add_data(n);
                close_record(1'b0);
                send_record(0, 0, 20, 1'b1);
            end else if (r < 82) begin
                rtype = 8'($urandom_range(0, 255));
                n = $urandom_range(0, 6);
                if ($urandom_range(0, 2) == 0) begin
                    start_record(8'(n + 1), next_offset, rtype);
                    add_data(n);
                    close_record($urandom_range(0, 1));
                    send_record(0, 0, 20, 1'b1);
                end else begin
                    start_record(8'(n), next_offset, rtype);
                    add_data(n);
                    close_record($urandom_range(0, 1));
                    if ($urandom_range(0, 1)) begin
                        send_record($urandom_range(1, 3), 0, 20, 1'b1);
                    end else begin
                        send_record(0, $urandom_range(1, 3), 20, 1'b1);
                    end
                end
            end else if (r < 90) begin
                send_skip_line($urandom_range(0, 12));
            end else begin
                send_char($urandom_range(0, 1) ? ihex_pkg::CHAR_CR : ihex_pkg::CHAR_LF);
            end
        end
        quiet_sender = 1'b0;
    endtask

    task test_halt();
        case ($urandom_range(0, 3))
            0: begin
                halt_name = "end of file";
                start_record(8'd0, 16'h0000, ihex_pkg::REC_EOF);
                close_record(1'b0);
            end
            1: begin
                halt_name = "checksum error";
                start_record(8'd2, next_offset, ihex_pkg::REC_DATA);
                add_data(2);
                close_record(1'b1);
            end
            2: begin
                halt_name = "start segment record";
                start_record(8'd4, 16'h0000, ihex_pkg::REC_START_SEG);
                add_data(4);
                close_record(1'b0);
            end
            default: begin
                halt_name = "start linear record";
                start_record(8'd4, 16'h0000, ihex_pkg::REC_START_LIN);
                add_data(4);
                close_record(1'b0);
            end
        endcase
        send_record(0, 0, 0, 1'b1);
        // Everything after the halt must be dropped silently.
        start_record(8'd3, 16'h0040, ihex_pkg::REC_DATA);
        add_data(3);
        close_record(1'b0);
        send_record(0, 0, 0, 1'b1);
        send_skip_line(6);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_data_records();
        test_base_records();
        test_ignored_lines();
        test_overlong_line();
        wait_idle();
        test_random_stream();
        test_halt();
        wait_idle();
        $display("Sent %0d record lines (%0d record characters) over %0d cycles.",
                 record_lines, record_chars, cycle_count);
        $display("Checked %0d data bytes, %0d good, %0d ignored; stopped by %s.",
                 kind_seen[ihex_pkg::KIND_DATA], kind_seen[ihex_pkg::KIND_RECORD_OK],
                 kind_seen[ihex_pkg::KIND_IGNORED], halt_name);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_parse.sv
hw/rtl/intel_hex_record_decoder_core.sv
hw/rtl/ihex_checker.sv
sim/intel_hex_record_decoder_core_tb.sv
